[hw/rtl/ezq_pkg.sv]
package ezq_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_ITER_DEF  = 16;

  localparam int XW = 35;
  localparam int ZW = 36;
  localparam int AW = 36;
  localparam int QW = 66;
  localparam int OW = 16;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(64'sd652032874);

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  function automatic logic signed [AW-1:0] rnd30(logic signed [XW-1:0] a,
                                                 logic signed [XW-1:0] b);
    logic signed [2*XW-1:0] p;
    logic signed [2*XW-1:0] q;
    p = a * b;
    q = (p + (2*XW)'(64'sd536870912)) >>> 30;
    return q[AW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] to_q14(logic signed [QW:0] s);
    logic signed [QW:0] r;
    r = (s + (QW+1)'(64'sd35184372088832)) >>> 46;
    if (r > (QW+1)'(16384)) r = (QW+1)'(16384);
    if (r < -(QW+1)'(16384)) r = -(QW+1)'(16384);
    return r[OW-1:0];
  endfunction

endpackage

[hw/rtl/euler_zyx_to_quaternion_core.sv]
// ZYX Euler angles to unit quaternion. Each word carries roll, pitch and
// yaw as binary angles (half a turn is 2^(ANGLE_BITS-1)) and yields one
// quaternion w, x, y, z in signed Q1.14, held to plus or minus one. The
// pipeline takes one word per cycle while it is not stalled, through
// an input register, one CORDIC step per stage for the three half angles,
// two multiply stages and a round and saturate stage that is also the
// output register. A stall of a valid output word freezes the whole pipeline.
module euler_zyx_to_quaternion_core
  import ezq_pkg::*;
#(
  parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] in_yaw_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OW-1:0]         out_quat_w,
  output logic signed [OW-1:0]         out_quat_x,
  output logic signed [OW-1:0]         out_quat_y,
  output logic signed [OW-1:0]         out_quat_z
);

  localparam int NS = TRIG_ITERATIONS + 4;

  logic          en;
  logic [NS-1:0] vld_r;

  logic signed [XW-1:0] cx [3][TRIG_ITERATIONS+1];
  logic signed [XW-1:0] cy [3][TRIG_ITERATIONS+1];
  logic signed [ZW-1:0] cz [3][TRIG_ITERATIONS+1];

  assign en       = !(vld_r[NS-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0][0] <= CORDIC_GAIN;
      cx[1][0] <= CORDIC_GAIN;
      cx[2][0] <= CORDIC_GAIN;
      cy[0][0] <= '0;
      cy[1][0] <= '0;
      cy[2][0] <= '0;
      cz[0][0] <= ZW'(in_roll_angle)  <<< (33 - ANGLE_BITS);
      cz[1][0] <= ZW'(in_pitch_angle) <<< (33 - ANGLE_BITS);
      cz[2][0] <= ZW'(in_yaw_angle)   <<< (33 - ANGLE_BITS);
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_step
      ezq_cordic_stage #(.SHIFT(i)) u_step (
        .clk (clk),
        .en  (en),
        .x_i (cx[j][i]),
        .y_i (cy[j][i]),
        .z_i (cz[j][i]),
        .x_r (cx[j][i+1]),
        .y_r (cy[j][i+1]),
        .z_r (cz[j][i+1])
      );
    end
  end

  logic signed [AW-1:0] cc_r, ss_r, sc_r, cs_r;
  logic signed [XW-1:0] cyaw_r, syaw_r;
  logic signed [QW-1:0] p_r [8];

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r   <= rnd30(cx[0][TRIG_ITERATIONS], cx[1][TRIG_ITERATIONS]);
      ss_r   <= rnd30(cy[0][TRIG_ITERATIONS], cy[1][TRIG_ITERATIONS]);
      sc_r   <= rnd30(cy[0][TRIG_ITERATIONS], cx[1][TRIG_ITERATIONS]);
      cs_r   <= rnd30(cx[0][TRIG_ITERATIONS], cy[1][TRIG_ITERATIONS]);
      cyaw_r <= cx[2][TRIG_ITERATIONS];
      syaw_r <= cy[2][TRIG_ITERATIONS];
      p_r[0] <= QW'(cc_r * cyaw_r);
      p_r[1] <= QW'(ss_r * syaw_r);
      p_r[2] <= QW'(sc_r * cyaw_r);
      p_r[3] <= QW'(cs_r * syaw_r);
      p_r[4] <= QW'(cs_r * cyaw_r);
      p_r[5] <= QW'(sc_r * syaw_r);
      p_r[6] <= QW'(cc_r * syaw_r);
      p_r[7] <= QW'(ss_r * cyaw_r);
      out_quat_w <= to_q14((QW+1)'(p_r[0]) + (QW+1)'(p_r[1]));
      out_quat_x <= to_q14((QW+1)'(p_r[2]) - (QW+1)'(p_r[3]));
      out_quat_y <= to_q14((QW+1)'(p_r[4]) + (QW+1)'(p_r[5]));
      out_quat_z <= to_q14((QW+1)'(p_r[6]) - (QW+1)'(p_r[7]));
    end
  end

endmodule

[hw/rtl/ezq_cordic_stage.sv]
module ezq_cordic_stage
  import ezq_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0] x_r,
  output logic signed [XW-1:0] y_r,
  output logic signed [ZW-1:0] z_r
);

  localparam logic signed [ZW-1:0] DA = ZW'({ATAN_TAB[SHIFT], 2'b00});

  logic signed [XW-1:0] dx, dy;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;

  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - DA;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + DA;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

[tb/ezq_scoreboard.sv]
`timescale 1ns / 1ps

module ezq_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_yaw_angle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_quat_w,
  input  logic signed [15:0] out_quat_x,
  input  logic signed [15:0] out_quat_y,
  input  logic signed [15:0] out_quat_z,
  output int                 fail_count,
  output int                 quats_pending
);

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  localparam longint GAIN_Q30 = 64'sd652032874;

  longint atan_q31 [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861
  };

  quat_t quat_q[$];

  function automatic void half_sincos(input logic signed [15:0] ang, output longint c,
                                      output longint s);
    longint z;
    longint cx;
    longint sy;
    longint dx;
    longint dy;
    z  = longint'(ang) * (64'sd1 << 17);
    cx = GAIN_Q30;
    sy = 0;
    for (int i = 0; i < 16; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx;
        sy += dy;
        z  -= atan_q31[i] * 4;
      end else begin
        cx += dx;
        sy -= dy;
        z  += atan_q31[i] * 4;
      end
    end
    c = cx;
    s = sy;
  endfunction

  function automatic longint prod3(longint a, longint b, longint c);
    longint ab;
    ab = (a * b + (64'sd1 << 29)) >>> 30;
    return ab * c;
  endfunction

  function automatic logic signed [15:0] sat_q14(longint v);
    longint r;
    r = (v + (64'sd1 << 45)) >>> 46;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic quat_t euler_to_quat(logic signed [15:0] roll,
                                          logic signed [15:0] pitch,
                                          logic signed [15:0] yaw);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_sincos(roll, cr, sr);
    half_sincos(pitch, cp, sp);
    half_sincos(yaw, cy, sy);
    q.w = sat_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.x = sat_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.y = sat_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.z = sat_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    return q;
  endfunction

  assign quats_pending = quat_q.size();

  always @(posedge clk) begin
    quat_t q;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        quat_q.push_back(euler_to_quat(in_roll_angle, in_pitch_angle, in_yaw_angle));
      if (out_valid && !out_stall) begin
        if (quat_q.size() == 0) begin
          $error("unexpected output word");
          fail_count <= fail_count + 1;
        end else begin
          q = quat_q.pop_front();
          if (out_quat_w !== q.w || out_quat_x !== q.x || out_quat_y !== q.y ||
              out_quat_z !== q.z) begin
            if (out_quat_w !== q.w) $error("quat_w exp %0d got %0d", q.w, out_quat_w);
            if (out_quat_x !== q.x) $error("quat_x exp %0d got %0d", q.x, out_quat_x);
            if (out_quat_y !== q.y) $error("quat_y exp %0d got %0d", q.y, out_quat_y);
            if (out_quat_z !== q.z) $error("quat_z exp %0d got %0d", q.z, out_quat_z);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_roll_angle = '0;
  logic signed [15:0] in_pitch_angle = '0;
  logic signed [15:0] in_yaw_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  int                 fail_count;
  int                 quats_pending;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;

  logic signed [15:0] corner [7] = '{16'sh0000, 16'sh7fff, -16'sh8000, -16'sh0001,
                                     16'sh0001, 16'sh4000, -16'sh4000};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_zyx_to_quaternion_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_roll_angle, .in_pitch_angle,
    .in_yaw_angle, .out_valid, .out_stall, .out_quat_w, .out_quat_x,
    .out_quat_y, .out_quat_z
  );

  ezq_scoreboard checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_roll_angle, .in_pitch_angle,
    .in_yaw_angle, .out_valid, .out_stall, .out_quat_w, .out_quat_x,
    .out_quat_y, .out_quat_z, .fail_count, .quats_pending
  );

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                           input logic signed [15:0] yaw);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_roll_angle  <= roll;
    in_pitch_angle <= pitch;
    in_yaw_angle   <= yaw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_angle();
    if ($urandom_range(5) == 0) return corner[$urandom_range(6)];
    return 16'($urandom());
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 7; i++) send_word(corner[i], corner[i], corner[i]);
    for (int i = 0; i < 7; i++) send_word(corner[i], corner[(i + 2) % 7], corner[(i + 5) % 7]);
    send_word(16'sh7fff, 16'sh0000, 16'sh0000);
    send_word(16'sh0000, -16'sh8000, 16'sh0000);
    send_word(16'sh0000, 16'sh0000, 16'sh5555);
    send_word(-16'sh5556, 16'sh2aaa, -16'sh8000);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 31 : 0;
      stall_pct = (ph == 2) ? 78 : (ph == 3) ? 31 : 0;
      repeat (113) send_word(pick_angle(), pick_angle(), pick_angle());
    end
    in_valid <= 1'b0;
    while (quats_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
